// ===== src/knnom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnom_pkg
// Shared types, constants and codes of the nearest-neighbour observation
// memory.
// ----------------------------------------------------------------------------
package knnom_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_K_DEF    = 16;

    localparam int COORD_W    = 16;
    localparam int RATIO_W    = 17;
    localparam int DIST_W     = 34;
    localparam int NIN_W      = 7;
    localparam int KREG_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;
    localparam int FRAC_W     = 16;

    // Squared-distance pipeline: read, difference and products, sums.
    localparam int DRAIN_CYCLES = 3;

    localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [NIN_W-1:0]   N_IN_USE_RST = 7'd64;
    localparam logic [KREG_W-1:0]  K_RST        = 5'd5;
    localparam logic [DIST_W-1:0]  DLIM_RST     = 34'd65536;
    localparam logic [RATIO_W-1:0] UNKNOWN_RST  = 17'd32768;
    localparam logic [RATIO_W-1:0] MAX_ERR_RST  = 17'd16384;
    localparam logic [RATIO_W-1:0] MIN_CONF_RST = 17'd32768;

    localparam logic CMD_ESTIMATE = 1'b0;
    localparam logic CMD_UPDATE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_IN_USE,
        CFG_K_NEIGHBORS,
        CFG_DIST_LIMIT,
        CFG_UNKNOWN,
        CFG_MAX_ERROR,
        CFG_MIN_CONF
    } cfg_idx_t;

    typedef struct packed {
        logic                       command;
        logic signed [COORD_W-1:0]  view_x;
        logic signed [COORD_W-1:0]  view_y;
        logic signed [COORD_W-1:0]  view_z;
        logic                       observed;
    } in_item_t;

    typedef struct packed {
        logic [RATIO_W-1:0] estimate;
        logic [RATIO_W-1:0] confidence;
        logic [RATIO_W-1:0] positive_ratio;
        logic               changed;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      s;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_DRAIN,
        S_EST_RES,
        S_DIV_EST,
        S_DIV_CONF,
        S_VICTIM,
        S_SHIFT_SETUP,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_APPEND,
        S_RATIO,
        S_DIV_RATIO,
        S_DONE
    } st_t;

    typedef enum logic [1:0] {
        DIV_EST,
        DIV_CONF,
        DIV_RATIO
    } div_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     rd_en;
        logic     rd_shift;
        logic     victim_load;
        logic     victim_walk;
        logic     append;
        logic     div_start;
        logic     div_capture;
        div_sel_t div_sel;
        logic     est_unknown;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_update;
        logic empty;
        logic full;
        logic skip;
        logic low_conf;
        logic any_cand;
        logic div_done;
    } dp_status_t;

endpackage

// ===== src/knnom_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnom_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface knnom_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/knnom_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnom_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module knnom_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (!busy_reg && start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== src/knnom_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnom_dp
// Datapath: observation store, distance pipeline, nearest-k list, victim
// search, configuration registers and result register.
// ----------------------------------------------------------------------------
module knnom_dp #(
    parameter int CAPACITY = knnom_pkg::CAPACITY_DEF,
    parameter int MAX_K    = knnom_pkg::MAX_K_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  knnom_pkg::ctrl_cmd_t                cmd,
    output knnom_pkg::dp_status_t               status,
    input  knnom_pkg::in_item_t                 in_data,
    output knnom_pkg::out_item_t                out_data,
    input  logic                                cfg_wr_en,
    input  logic [knnom_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [knnom_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic [CNT_W-1:0]                    count,
    output logic [ADDR_W-1:0]                   victim
);

    localparam int K_W   = $clog2(MAX_K + 1);
    localparam int LIM_W = (CNT_W > knnom_pkg::NIN_W) ? CNT_W : knnom_pkg::NIN_W;
    localparam int KL_W  = (K_W > knnom_pkg::KREG_W) ? K_W : knnom_pkg::KREG_W;
    localparam int V_W   = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int NUM_W = V_W + knnom_pkg::FRAC_W;
    localparam int RW    = knnom_pkg::RATIO_W;
    localparam int DW    = knnom_pkg::DIST_W;

    // Configuration registers.
    logic [knnom_pkg::NIN_W-1:0]  n_in_use_reg;
    logic [knnom_pkg::KREG_W-1:0] k_reg;
    logic [DW-1:0]                dlim_reg;
    logic [RW-1:0]                unknown_reg;
    logic [RW-1:0]                max_err_reg;
    logic [RW-1:0]                min_conf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_in_use_reg <= knnom_pkg::N_IN_USE_RST;
            k_reg        <= knnom_pkg::K_RST;
            dlim_reg     <= knnom_pkg::DLIM_RST;
            unknown_reg  <= knnom_pkg::UNKNOWN_RST;
            max_err_reg  <= knnom_pkg::MAX_ERR_RST;
            min_conf_reg <= knnom_pkg::MIN_CONF_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (knnom_pkg::cfg_idx_t'(cfg_index))
                knnom_pkg::CFG_N_IN_USE:    n_in_use_reg <= cfg_data[knnom_pkg::NIN_W-1:0];
                knnom_pkg::CFG_K_NEIGHBORS: k_reg        <= cfg_data[knnom_pkg::KREG_W-1:0];
                knnom_pkg::CFG_DIST_LIMIT:  dlim_reg     <= cfg_data[DW-1:0];
                knnom_pkg::CFG_UNKNOWN:     unknown_reg  <= cfg_data[RW-1:0];
                knnom_pkg::CFG_MAX_ERROR:   max_err_reg  <= cfg_data[RW-1:0];
                knnom_pkg::CFG_MIN_CONF:    min_conf_reg <= cfg_data[RW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective store limit and neighbour count.
    logic [LIM_W-1:0] limit;
    logic [KL_W-1:0]  k_lim;
    logic [K_W-1:0]   k_eff;

    always_comb
    begin
        if (n_in_use_reg == '0)
            limit = LIM_W'(1);
        else if (LIM_W'(n_in_use_reg) > LIM_W'(CAPACITY))
            limit = LIM_W'(CAPACITY);
        else
            limit = LIM_W'(n_in_use_reg);
        if (k_reg == '0)
            k_lim = KL_W'(1);
        else if (KL_W'(k_reg) > KL_W'(MAX_K))
            k_lim = KL_W'(MAX_K);
        else
            k_lim = KL_W'(k_reg);
        k_eff = k_lim[K_W-1:0];
    end

    // Latched query.
    knnom_pkg::in_item_t q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            q_reg <= in_data;
        end
    end

    // Store bookkeeping.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] victim_reg;
    logic              vstat_reg;
    logic              changed_reg;
    logic              full;

    assign full = LIM_W'(count_reg) >= limit;

    // Observation memory.
    knnom_pkg::entry_t mem [CAPACITY];
    knnom_pkg::entry_t rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_shift_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    knnom_pkg::entry_t mem_wdata;
    logic              shift_wr;

    assign shift_wr = rd_vld_reg && rd_shift_reg && (rd_addr_reg != victim_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr_reg - 1'b1;
        mem_wdata = rd_data_reg;
        if (shift_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.append)
        begin
            mem_we      = 1'b1;
            mem_waddr   = full ? ADDR_W'(count_reg - 1'b1) : ADDR_W'(count_reg);
            mem_wdata.x = q_reg.view_x;
            mem_wdata.y = q_reg.view_y;
            mem_wdata.z = q_reg.view_z;
            mem_wdata.s = q_reg.observed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Distance and dot-product pipeline.
    logic                 s1_vld_reg;
    logic [ADDR_W-1:0]    s1_idx_reg;
    logic                 s1_stat_reg;
    logic [32:0]          sqx_reg, sqy_reg, sqz_reg;
    logic signed [31:0]   px_reg, py_reg, pz_reg;

    logic signed [16:0]   dx, dy, dz;
    logic signed [33:0]   sqx, sqy, sqz;

    always_comb
    begin
        dx  = 17'(rd_data_reg.x) - 17'(q_reg.view_x);
        dy  = 17'(rd_data_reg.y) - 17'(q_reg.view_y);
        dz  = 17'(rd_data_reg.z) - 17'(q_reg.view_z);
        sqx = dx * dx;
        sqy = dy * dy;
        sqz = dz * dz;
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_addr_reg;
        s1_stat_reg <= rd_data_reg.s;
        sqx_reg     <= sqx[32:0];
        sqy_reg     <= sqy[32:0];
        sqz_reg     <= sqz[32:0];
        px_reg      <= rd_data_reg.x * q_reg.view_x;
        py_reg      <= rd_data_reg.y * q_reg.view_y;
        pz_reg      <= rd_data_reg.z * q_reg.view_z;
    end

    logic                 s2_vld_reg;
    logic [ADDR_W-1:0]    s2_idx_reg;
    logic                 s2_stat_reg;
    logic [DW-1:0]        s2_dist_reg;
    logic                 s2_cand_reg;
    logic [DW-1:0]        dist_sum;
    logic signed [33:0]   dot;

    always_comb
    begin
        dist_sum = DW'(sqx_reg) + DW'(sqy_reg) + DW'(sqz_reg);
        dot      = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_stat_reg <= s1_stat_reg;
        s2_dist_reg <= dist_sum;
        s2_cand_reg <= (dist_sum <= dlim_reg) && !dot[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_shift_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.rd_en;
            rd_shift_reg <= cmd.rd_shift;
            s1_vld_reg   <= rd_vld_reg && !rd_shift_reg;
            s2_vld_reg   <= s1_vld_reg;
        end
    end

    // Sorted list of the nearest candidates. A new entry goes after every
    // entry of equal distance, so the older entry keeps precedence.
    logic [DW-1:0]    l_dist_reg [MAX_K];
    logic             l_stat_reg [MAX_K];
    logic [K_W-1:0]   lcnt_reg;
    logic             any_cand_reg;
    logic [MAX_K-1:0] le_mask;
    logic [MAX_K-1:0] stat_mask;
    logic [K_W-1:0]   ins_pos;
    logic [K_W-1:0]   sum;
    logic [DW-1:0]    ins_dist [MAX_K];
    logic             ins_stat [MAX_K];
    logic             est_beat;

    assign est_beat = s2_vld_reg && s2_cand_reg && (q_reg.command == knnom_pkg::CMD_ESTIMATE);

    always_comb
    begin
        for (int j = 0; j < MAX_K; j++)
        begin
            le_mask[j]   = (K_W'(j) < lcnt_reg) && (l_dist_reg[j] <= s2_dist_reg);
            stat_mask[j] = (K_W'(j) < lcnt_reg) && l_stat_reg[j];
        end
        ins_pos = K_W'($countones(le_mask));
        sum     = K_W'($countones(stat_mask));
    end

    for (genvar j = 0; j < MAX_K; j++)
    begin : g_ins
        if (j == 0)
        begin : g_head
            always_comb
            begin
                ins_dist[j] = (ins_pos == '0) ? s2_dist_reg : l_dist_reg[j];
                ins_stat[j] = (ins_pos == '0) ? s2_stat_reg : l_stat_reg[j];
            end
        end
        else
        begin : g_body
            always_comb
            begin
                if (K_W'(j) == ins_pos)
                begin
                    ins_dist[j] = s2_dist_reg;
                    ins_stat[j] = s2_stat_reg;
                end
                else if (K_W'(j) > ins_pos)
                begin
                    ins_dist[j] = l_dist_reg[j-1];
                    ins_stat[j] = l_stat_reg[j-1];
                end
                else
                begin
                    ins_dist[j] = l_dist_reg[j];
                    ins_stat[j] = l_stat_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (est_beat && (ins_pos < k_eff))
        begin
            for (int j = 0; j < MAX_K; j++)
            begin
                l_dist_reg[j] <= ins_dist[j];
                l_stat_reg[j] <= ins_stat[j];
            end
        end
    end

    // Victim search: nearest entry of opposite status, lower slot on ties.
    logic              found_reg;
    logic [DW-1:0]     best_d_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic              upd_beat;

    assign upd_beat = s2_vld_reg && (q_reg.command == knnom_pkg::CMD_UPDATE)
                      && (s2_stat_reg != q_reg.observed)
                      && (!found_reg || (s2_dist_reg < best_d_reg));

    always_ff @(posedge clk)
    begin
        if (upd_beat)
        begin
            best_d_reg   <= s2_dist_reg;
            best_idx_reg <= s2_idx_reg;
        end
        if (rd_vld_reg && rd_shift_reg && (rd_addr_reg == victim_reg))
        begin
            vstat_reg <= rd_data_reg.s;
        end
    end

    // Divider.
    logic [NUM_W-1:0] div_num;
    logic [V_W-1:0]   div_den;
    logic [NUM_W-1:0] div_quo;
    logic             div_done;

    always_comb
    begin
        unique case (cmd.div_sel)
            knnom_pkg::DIV_EST:
            begin
                div_num = {V_W'(sum), knnom_pkg::FRAC_W'(0)};
                div_den = V_W'(lcnt_reg);
            end
            knnom_pkg::DIV_CONF:
            begin
                div_num = {V_W'(lcnt_reg), knnom_pkg::FRAC_W'(0)};
                div_den = V_W'(k_eff);
            end
            knnom_pkg::DIV_RATIO:
            begin
                div_num = {V_W'(pos_reg), knnom_pkg::FRAC_W'(0)};
                div_den = V_W'(count_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = V_W'(1);
            end
        endcase
    end

    knnom_div #(
        .NUM_W (NUM_W),
        .DEN_W (V_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // Control-side state.
    logic [RW-1:0] last_est_reg;
    logic [RW-1:0] last_conf_reg;
    logic [RW-1:0] saved_ratio_reg;
    logic [RW-1:0] unknown_sat;

    assign unknown_sat = (unknown_reg > knnom_pkg::ONE_Q16) ? knnom_pkg::ONE_Q16 : unknown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pos_reg         <= '0;
            victim_reg      <= '0;
            changed_reg     <= 1'b0;
            lcnt_reg        <= '0;
            any_cand_reg    <= 1'b0;
            found_reg       <= 1'b0;
            last_est_reg    <= '0;
            last_conf_reg   <= '0;
            saved_ratio_reg <= '0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                lcnt_reg     <= '0;
                any_cand_reg <= 1'b0;
                found_reg    <= 1'b0;
                changed_reg  <= 1'b0;
            end
            else
            begin
                if (est_beat)
                begin
                    any_cand_reg <= 1'b1;
                    if (lcnt_reg < k_eff)
                    begin
                        lcnt_reg <= lcnt_reg + 1'b1;
                    end
                end
                if (upd_beat)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.victim_load)
            begin
                victim_reg <= (cmd.victim_walk && found_reg) ? best_idx_reg : '0;
            end
            if (cmd.append)
            begin
                changed_reg <= full;
                if (full)
                begin
                    pos_reg <= pos_reg - CNT_W'(vstat_reg) + CNT_W'(q_reg.observed);
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    pos_reg   <= pos_reg + CNT_W'(q_reg.observed);
                end
            end
            if (cmd.est_unknown)
            begin
                last_est_reg  <= unknown_sat;
                last_conf_reg <= '0;
            end
            if (cmd.div_capture)
            begin
                unique case (cmd.div_sel)
                    knnom_pkg::DIV_EST:   last_est_reg    <= div_quo[RW-1:0];
                    knnom_pkg::DIV_CONF:  last_conf_reg   <= div_quo[RW-1:0];
                    knnom_pkg::DIV_RATIO: saved_ratio_reg <= div_quo[RW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Full-store decision inputs.
    logic [RW-1:0] target;
    logic [RW-1:0] err;
    logic          confident;

    always_comb
    begin
        target    = q_reg.observed ? knnom_pkg::ONE_Q16 : '0;
        err       = (target > last_est_reg) ? (target - last_est_reg)
                                            : (last_est_reg - target);
        confident = last_conf_reg > min_conf_reg;
    end

    // Result register.
    knnom_pkg::out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (q_reg.command == knnom_pkg::CMD_ESTIMATE)
            begin
                out_reg.estimate       <= last_est_reg;
                out_reg.confidence     <= last_conf_reg;
                out_reg.positive_ratio <= '0;
                out_reg.changed        <= 1'b0;
            end
            else
            begin
                out_reg.estimate       <= '0;
                out_reg.confidence     <= '0;
                out_reg.positive_ratio <= saved_ratio_reg;
                out_reg.changed        <= changed_reg;
            end
        end
    end

    assign out_data = out_reg;
    assign count    = count_reg;
    assign victim   = victim_reg;

    always_comb
    begin
        status.is_update = (q_reg.command == knnom_pkg::CMD_UPDATE);
        status.empty     = (count_reg == '0);
        status.full      = full;
        status.skip      = (err < max_err_reg) && confident;
        status.low_conf  = !confident;
        status.any_cand  = any_cand_reg;
        status.div_done  = div_done;
    end

endmodule

// ===== src/knnom_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnom_ctrl
// Command sequencer: store walks, shifts, divisions and result hand-off.
// ----------------------------------------------------------------------------
module knnom_ctrl #(
    parameter int CAPACITY = knnom_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  knnom_pkg::dp_status_t  status,
    output knnom_pkg::ctrl_cmd_t   cmd,
    input  logic [CNT_W-1:0]       count,
    input  logic [ADDR_W-1:0]      victim,
    output logic [ADDR_W-1:0]      rd_addr
);

    knnom_pkg::st_t    state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [1:0]        drain_reg, drain_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_ptr;
    logic              drain_last;
    logic              out_free;

    assign last_ptr   = (CNT_W'(ptr_reg) + 1'b1) == count;
    assign drain_last = drain_reg == 2'(knnom_pkg::DRAIN_CYCLES - 1);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knnom_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = knnom_pkg::S_DECIDE;
            end
            knnom_pkg::S_DECIDE:
            begin
                priority if (!status.is_update)
                    state_next = status.empty ? knnom_pkg::S_EST_RES : knnom_pkg::S_WALK;
                else if (!status.full)
                    state_next = knnom_pkg::S_APPEND;
                else if (status.skip)
                    state_next = knnom_pkg::S_DONE;
                else if (status.low_conf)
                    state_next = knnom_pkg::S_SHIFT_SETUP;
                else
                    state_next = knnom_pkg::S_WALK;
            end
            knnom_pkg::S_WALK:
            begin
                if (last_ptr)
                    state_next = knnom_pkg::S_DRAIN;
            end
            knnom_pkg::S_DRAIN:
            begin
                if (drain_last)
                    state_next = status.is_update ? knnom_pkg::S_VICTIM : knnom_pkg::S_EST_RES;
            end
            knnom_pkg::S_EST_RES:
            begin
                state_next = status.any_cand ? knnom_pkg::S_DIV_EST : knnom_pkg::S_DONE;
            end
            knnom_pkg::S_DIV_EST:
            begin
                if (status.div_done)
                    state_next = knnom_pkg::S_DIV_CONF;
            end
            knnom_pkg::S_DIV_CONF:
            begin
                if (status.div_done)
                    state_next = knnom_pkg::S_DONE;
            end
            knnom_pkg::S_VICTIM:      state_next = knnom_pkg::S_SHIFT_SETUP;
            knnom_pkg::S_SHIFT_SETUP: state_next = knnom_pkg::S_SHIFT;
            knnom_pkg::S_SHIFT:
            begin
                if (last_ptr)
                    state_next = knnom_pkg::S_SHIFT_DRAIN;
            end
            knnom_pkg::S_SHIFT_DRAIN: state_next = knnom_pkg::S_APPEND;
            knnom_pkg::S_APPEND:      state_next = knnom_pkg::S_RATIO;
            knnom_pkg::S_RATIO:       state_next = knnom_pkg::S_DIV_RATIO;
            knnom_pkg::S_DIV_RATIO:
            begin
                if (status.div_done)
                    state_next = knnom_pkg::S_DONE;
            end
            knnom_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = knnom_pkg::S_IDLE;
            end
            default: state_next = knnom_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = knnom_pkg::DIV_EST;
        in_ready       = 1'b0;
        ptr_next       = ptr_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            knnom_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            knnom_pkg::S_DECIDE:
            begin
                ptr_next        = '0;
                drain_next      = '0;
                cmd.victim_load = status.is_update && status.full && !status.skip
                                  && status.low_conf;
            end
            knnom_pkg::S_WALK:
            begin
                cmd.rd_en = 1'b1;
                ptr_next  = ptr_reg + 1'b1;
            end
            knnom_pkg::S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
            end
            knnom_pkg::S_EST_RES:
            begin
                cmd.est_unknown = !status.any_cand;
                cmd.div_start   = status.any_cand;
                cmd.div_sel     = knnom_pkg::DIV_EST;
            end
            knnom_pkg::S_DIV_EST:
            begin
                cmd.div_sel     = knnom_pkg::DIV_EST;
                cmd.div_capture = status.div_done;
            end
            knnom_pkg::S_DIV_CONF:
            begin
                // The second division starts as soon as the first has gone idle,
                // and is not restarted in the cycle that it finishes.
                cmd.div_sel     = knnom_pkg::DIV_CONF;
                cmd.div_start   = !status.div_done;
                cmd.div_capture = status.div_done;
            end
            knnom_pkg::S_VICTIM:
            begin
                cmd.victim_load = 1'b1;
                cmd.victim_walk = 1'b1;
            end
            knnom_pkg::S_SHIFT_SETUP:
            begin
                ptr_next = victim;
            end
            knnom_pkg::S_SHIFT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_shift = 1'b1;
                ptr_next     = ptr_reg + 1'b1;
            end
            knnom_pkg::S_SHIFT_DRAIN:
            begin
            end
            knnom_pkg::S_APPEND:
            begin
                cmd.append = 1'b1;
            end
            knnom_pkg::S_RATIO:
            begin
                cmd.div_sel   = knnom_pkg::DIV_RATIO;
                cmd.div_start = 1'b1;
            end
            knnom_pkg::S_DIV_RATIO:
            begin
                cmd.div_sel     = knnom_pkg::DIV_RATIO;
                cmd.div_capture = status.div_done;
            end
            knnom_pkg::S_DONE:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= knnom_pkg::S_IDLE;
            ptr_reg       <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rd_addr   = ptr_reg;

endmodule

// ===== src/knn_observation_memory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_observation_memory
// Nearest-neighbour store of viewpoint observations with estimate and update
// commands.
// ----------------------------------------------------------------------------
// One command is worked at a time. An estimate streams the N stored entries
// through the distance pipeline at one per cycle and then runs two divisions
// on the bit-serial divider, which is 16 bits wider than the larger of
// clog2(CAPACITY+1) and clog2(MAX_K+1) (23 bits at the defaults); with no
// candidate the divisions are skipped. An update that appends runs one
// division for the positive ratio; a full-store replacement adds a walk of
// the store when it searches for a victim, and a shift of the entries above
// the victim slot. A confident and correct update is answered without a walk,
// shift or division. A new command is taken while the previous result still
// waits in the output register. The store itself needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module knn_observation_memory #(
    parameter int CAPACITY = knnom_pkg::CAPACITY_DEF,
    parameter int MAX_K    = knnom_pkg::MAX_K_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    knnom_chan_if.sink                        in_ch,
    knnom_chan_if.source                      out_ch,
    input  logic                              cfg_wr_en,
    input  logic [knnom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [knnom_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    knnom_pkg::ctrl_cmd_t  cmd;
    knnom_pkg::dp_status_t status;
    logic [CNT_W-1:0]      count;
    logic [ADDR_W-1:0]     victim;
    logic [ADDR_W-1:0]     rd_addr;

    knnom_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd),
        .count     (count),
        .victim    (victim),
        .rd_addr   (rd_addr)
    );

    knnom_dp #(
        .CAPACITY (CAPACITY),
        .MAX_K    (MAX_K),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_ch.data),
        .out_data  (out_ch.data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .count     (count),
        .victim    (victim)
    );

endmodule
